### rtl/mdl_pkg.sv
`default_nettype none

package mdl_pkg;

   localparam int unsigned FIELD_W = 6;

   // Request kinds carried on req_tuser
   localparam logic [1:0] REQ_TOUCH  = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_RESIZE = 2'd2;

   // Broadcast to every cell for the transaction being taken
   typedef struct packed {
      logic               update;
      logic               touch_en;
      logic               grow_en;
      logic               shrink_en;
      logic               any_match;
      logic [FIELD_W-1:0] desktop;
      logic [FIELD_W-1:0] size;
      logic [FIELD_W-1:0] length;
   } mdl_cmd_type;

   // Handed from each cell to the next one down the row
   typedef struct packed {
      logic               seen;    // a match exists in an earlier slot
      logic               first;   // this slot holds the first match
      logic               hit;     // query successor found so far
      logic [FIELD_W-1:0] value;   // query successor value so far
   } mdl_link_type;

endpackage

`default_nettype wire

### rtl/mdl_cell.sv
`default_nettype none

module mdl_cell #(
   parameter int unsigned INDEX = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  mdl_pkg::mdl_cmd_type  cmd,
   input  wire  [mdl_pkg::FIELD_W-1:0] prev_entry,
   input  wire  mdl_pkg::mdl_link_type link_in,
   output mdl_pkg::mdl_link_type     link_out,
   output logic [mdl_pkg::FIELD_W-1:0] entry
);
   import mdl_pkg::*;

   localparam logic [FIELD_W-1:0] SLOT      = FIELD_W'(INDEX);
   localparam logic [FIELD_W-1:0] SLOT_NEXT = FIELD_W'(INDEX + 1);

   logic [FIELD_W-1:0] entry_ff, entry_in;
   logic               in_list, match, shift;

   always_comb begin
      in_list = SLOT < cmd.length;
      match   = in_list && (entry_ff == cmd.desktop);

      link_out.first = match && !link_in.seen;
      link_out.seen  = link_in.seen || match;
      // successor of the first match, only if it lies inside the list
      link_out.hit   = link_in.hit || (link_in.first && in_list);
      link_out.value = (link_in.first && in_list) ? entry_ff : link_in.value;

      // slots up to the removed one move back by one
      shift = cmd.any_match ? !link_in.seen : in_list;

      entry_in = entry_ff;
      if (cmd.touch_en && shift) begin
         entry_in = prev_entry;
      end else if (cmd.grow_en && !in_list && (SLOT < cmd.size)) begin
         entry_in = SLOT_NEXT;
      end else if (cmd.shrink_en && (SLOT < cmd.size) && (entry_ff > cmd.size)) begin
         entry_in = cmd.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= SLOT_NEXT;
      end else if (cmd.update) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

### rtl/mru_desktop_list.sv
`default_nettype none
// Move-to-front list of desktop numbers.
// Input channel req_*: one transaction per request. req_tuser carries the
// request kind (touch, query next, resize); req_tdata carries desktop in
// bits 5:0 and the requested list size in bits 11:6.
// Result channel rsp_*: exactly one transaction per request, in order.
// rsp_tdata[5:0] is result_desktop, rsp_tuser is the accepted flag.
// rsp_tvalid rises in the cycle after req acceptance. Throughput is one
// request per cycle while the receiver does not stall: each list slot
// is a cell that compares its entry with the request and takes its
// neighbour's entry in the same cycle, so touch, query and resize all complete.
// The result sits in one output register; a new request is taken while
// that register is empty or being drained. When the receiver stalls with
// a result pending, req_tready drops until the result is taken.
// Reset (synchronous) empties the list (length zero), loads slot i with
// i+1 and discards any pending result.
module mru_desktop_list #(
   parameter int unsigned MAX_DESKTOPS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // desktop [5:0], req_size [11:6], zero pad
   input  wire  [1:0]  req_tuser,   // req_type [1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // result_desktop [5:0], zero pad
   output logic        rsp_tuser    // accepted [0]
);
   import mdl_pkg::*;

   localparam logic [FIELD_W-1:0] MAX_SIZE = FIELD_W'(MAX_DESKTOPS);
   localparam logic [FIELD_W-1:0] ONE      = FIELD_W'(1);

   logic [FIELD_W-1:0] length_ff, length_in;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] result_ff, result_in;
   logic               accepted_ff, accepted_in;

   logic               take;
   logic [FIELD_W-1:0] desktop, req_size, size_sat;
   logic [1:0]         req_type;
   logic               touch_ok;
   mdl_cmd_type        cmd;

   mdl_link_type       links [MAX_DESKTOPS+1];
   logic [FIELD_W-1:0] entries [MAX_DESKTOPS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign desktop    = req_tdata[5:0];
   assign req_size   = req_tdata[11:6];
   assign req_type   = req_tuser;

   assign links[0] = '0;

   generate
      for (genvar i = 0; i < MAX_DESKTOPS; i++) begin : g_cell
         mdl_cell #(
            .INDEX(i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_entry((i == 0) ? desktop : entries[(i == 0) ? 0 : i-1]),
            .link_in   (links[i]),
            .link_out  (links[i+1]),
            .entry     (entries[i])
         );
      end
   endgenerate

   always_comb begin
      size_sat = (req_size > MAX_SIZE) ? MAX_SIZE : req_size;
      touch_ok = (length_ff != '0) && (desktop <= length_ff);

      cmd.update    = take;
      cmd.touch_en  = (req_type == REQ_TOUCH) && touch_ok;
      cmd.grow_en   = (req_type == REQ_RESIZE) && (size_sat >= length_ff);
      cmd.shrink_en = (req_type == REQ_RESIZE) && (size_sat < length_ff);
      cmd.any_match = links[MAX_DESKTOPS].seen;
      cmd.desktop   = desktop;
      cmd.size      = size_sat;
      cmd.length    = length_ff;

      length_in   = length_ff;
      result_in   = '0;
      accepted_in = 1'b1;
      case (req_type)
         REQ_TOUCH: begin
            accepted_in = touch_ok;
         end
         REQ_QUERY: begin
            if (links[MAX_DESKTOPS].hit) begin
               result_in = links[MAX_DESKTOPS].value;
            end else if (length_ff != '0) begin
               result_in = entries[0];
            end else begin
               result_in = ONE;
            end
         end
         REQ_RESIZE: begin
            length_in = size_sat;
         end
         default: begin
            length_in = length_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            length_ff <= length_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff   <= result_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff};
   assign rsp_tuser  = accepted_ff;

   // list never grows past the number of cells
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= MAX_SIZE)
      else $error("list length beyond cell count");

   // every request taken yields a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("request produced no result");

   // an ignored touch carries no desktop number
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !accepted_ff) |-> (result_ff == '0))
      else $error("rejected touch with nonzero result");

   // length only changes when a request is taken
   a_length_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(length_ff))
      else $error("length changed without a request");

endmodule

`default_nettype wire
